// ===== rtl/acp_pkg.sv =====
// acp_pkg: shared types, character codes and constants of the command parser
// used by rtl/axis_command_parser.sv; no other dependencies

package acp_pkg;

  localparam int FIELD_BITS        = 24;
  localparam int NUMBER_BITS_DEF   = 24;
  localparam int MESSAGE_BYTES_DEF = 20;
  localparam int RESET_TEXT_LEN    = 10;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_Z     = 8'h5a;
  localparam logic [7:0] CH_S     = 8'h53;

  typedef enum logic [2:0] {
    LETTER_NONE  = 3'd0,
    LETTER_X     = 3'd1,
    LETTER_Y     = 3'd2,
    LETTER_Z     = 3'd3,
    LETTER_S     = 3'd4,
    LETTER_OTHER = 3'd5
  } letter_t;

  typedef enum logic [3:0] {
    STAGE_BEFORE_SIGN = 4'b0001,
    STAGE_AFTER_SIGN  = 4'b0010,
    STAGE_DIGITS      = 4'b0100,
    STAGE_DONE        = 4'b1000
  } stage_t;

  typedef enum logic [1:0] {
    KIND_MOVE  = 2'd0,
    KIND_RESET = 2'd1,
    KIND_SPEED = 2'd2
  } kind_t;

  // characters of the reset command text
  function automatic logic [7:0] reset_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "r";
      4'd1:    c = "e";
      4'd2:    c = "s";
      4'd3:    c = "e";
      4'd4:    c = "t";
      4'd5:    c = "C";
      4'd6:    c = "o";
      4'd7:    c = "o";
      4'd8:    c = "r";
      4'd9:    c = "d";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/axis_command_parser.sv =====
// axis_command_parser: byte-wise text command decoder, one result per frame
// depends on acp_pkg
//
//   beat        valid     stall     payload
//   in          in_valid  in_stall  rx_byte, frame_last
//   out         out_valid out_stall command_kind, target_x/y/z, speed_value
//
// one byte is taken every cycle while in_stall is low; the parse state steps once per byte
// the frame result is loaded at the edge that takes its last byte
// a waiting result stalls the input only while out_stall holds it
// rst is synchronous and clears the parse state and out_valid

module axis_command_parser #(
  parameter int NUMBER_BITS   = acp_pkg::NUMBER_BITS_DEF,
  parameter int MESSAGE_BYTES = acp_pkg::MESSAGE_BYTES_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [7:0]                              rx_byte,
  input  logic                                    frame_last,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [1:0]                              command_kind,
  output logic signed [acp_pkg::FIELD_BITS-1:0]   target_x,
  output logic signed [acp_pkg::FIELD_BITS-1:0]   target_y,
  output logic signed [acp_pkg::FIELD_BITS-1:0]   target_z,
  output logic signed [acp_pkg::FIELD_BITS-1:0]   speed_value
);

  localparam int CNT_BITS = $clog2(MESSAGE_BYTES + 1);
  localparam int NB       = NUMBER_BITS;
  localparam int FB       = acp_pkg::FIELD_BITS;
  localparam logic [NB-1:0] MAG_LIMIT = {1'b1, {(NB-1){1'b0}}};
  localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MESSAGE_BYTES);
  localparam logic [3:0] RESET_LEN = 4'(acp_pkg::RESET_TEXT_LEN);

  // parse state
  logic                  token_phase, token_phase_next;
  acp_pkg::letter_t      token_letter, token_letter_next;
  acp_pkg::stage_t       number_stage, number_stage_next;
  logic                  number_negative, number_negative_next;
  logic [NB-1:0]         number_magnitude, number_magnitude_next;
  logic signed [NB-1:0]  x_latched, x_latched_next;
  logic signed [NB-1:0]  y_latched, y_latched_next;
  logic signed [NB-1:0]  z_latched, z_latched_next;
  logic                  speed_seen, speed_seen_next;
  logic signed [NB-1:0]  speed_latched, speed_latched_next;
  logic [3:0]            reset_match_pos, reset_match_pos_next;
  logic                  reset_match_failed, reset_match_failed_next;
  logic                  text_ended, text_ended_next;
  logic [CNT_BITS-1:0]   byte_count, byte_count_next;

  // result register
  acp_pkg::kind_t        kind_next;
  logic signed [FB-1:0]  x_out_next, y_out_next, z_out_next, s_out_next;

  logic in_accept;
  logic out_load;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_load  = in_accept && frame_last;

  always_comb begin
    logic                 digit;
    logic                 feed;
    logic                 space_fed;
    logic [NB+3:0]        acc;
    logic [NB-1:0]        mclip;
    logic signed [NB-1:0] value;

    token_phase_next        = token_phase;
    token_letter_next       = token_letter;
    number_stage_next       = number_stage;
    number_negative_next    = number_negative;
    number_magnitude_next   = number_magnitude;
    x_latched_next          = x_latched;
    y_latched_next          = y_latched;
    z_latched_next          = z_latched;
    speed_seen_next         = speed_seen;
    speed_latched_next      = speed_latched;
    reset_match_pos_next    = reset_match_pos;
    reset_match_failed_next = reset_match_failed;
    text_ended_next         = text_ended;
    byte_count_next         = byte_count;
    kind_next               = acp_pkg::KIND_MOVE;
    x_out_next              = '0;
    y_out_next              = '0;
    z_out_next              = '0;
    s_out_next              = '0;

    digit     = (rx_byte >= acp_pkg::CH_ZERO) && (rx_byte <= acp_pkg::CH_NINE);
    feed      = in_accept && !text_ended && (byte_count < CNT_MAX) &&
                (rx_byte != acp_pkg::CH_NUL);
    space_fed = feed && !speed_seen && (rx_byte == acp_pkg::CH_SPACE);
    acc       = ({4'b0, number_magnitude} << 3) + ({4'b0, number_magnitude} << 1) +
                (NB+4)'(rx_byte[3:0]);

    if (in_accept && !text_ended && (byte_count < CNT_MAX)) begin
      byte_count_next = byte_count + 1'b1;
      if (rx_byte == acp_pkg::CH_NUL) begin
        text_ended_next = 1'b1;
      end
    end

    if (feed) begin
      if (!reset_match_failed && (reset_match_pos < RESET_LEN) &&
          (rx_byte == acp_pkg::reset_char(reset_match_pos))) begin
        reset_match_pos_next = reset_match_pos + 4'd1;
      end else begin
        reset_match_failed_next = 1'b1;
      end

      if (!speed_seen && (rx_byte != acp_pkg::CH_SPACE)) begin
        if (!token_phase) begin
          token_phase_next      = 1'b1;
          number_stage_next     = acp_pkg::STAGE_BEFORE_SIGN;
          number_negative_next  = 1'b0;
          number_magnitude_next = '0;
          case (rx_byte)
            acp_pkg::CH_X: token_letter_next = acp_pkg::LETTER_X;
            acp_pkg::CH_Y: token_letter_next = acp_pkg::LETTER_Y;
            acp_pkg::CH_Z: token_letter_next = acp_pkg::LETTER_Z;
            acp_pkg::CH_S: token_letter_next = acp_pkg::LETTER_S;
            default:       token_letter_next = acp_pkg::LETTER_OTHER;
          endcase
        end else begin
          unique case (number_stage)
            acp_pkg::STAGE_BEFORE_SIGN: begin
              if (rx_byte == acp_pkg::CH_TAB || rx_byte == acp_pkg::CH_LF ||
                  rx_byte == acp_pkg::CH_VT || rx_byte == acp_pkg::CH_FF ||
                  rx_byte == acp_pkg::CH_CR) begin
                number_stage_next = acp_pkg::STAGE_BEFORE_SIGN;
              end else if (rx_byte == acp_pkg::CH_PLUS) begin
                number_stage_next = acp_pkg::STAGE_AFTER_SIGN;
              end else if (rx_byte == acp_pkg::CH_MINUS) begin
                number_negative_next = 1'b1;
                number_stage_next    = acp_pkg::STAGE_AFTER_SIGN;
              end else if (digit) begin
                number_stage_next     = acp_pkg::STAGE_DIGITS;
                number_magnitude_next = (acc > (NB+4)'(MAG_LIMIT)) ? MAG_LIMIT : acc[NB-1:0];
              end else begin
                number_stage_next = acp_pkg::STAGE_DONE;
              end
            end
            acp_pkg::STAGE_AFTER_SIGN, acp_pkg::STAGE_DIGITS: begin
              if (digit) begin
                number_stage_next     = acp_pkg::STAGE_DIGITS;
                number_magnitude_next = (acc > (NB+4)'(MAG_LIMIT)) ? MAG_LIMIT : acc[NB-1:0];
              end else begin
                number_stage_next = acp_pkg::STAGE_DONE;
              end
            end
            acp_pkg::STAGE_DONE: begin
              number_stage_next = acp_pkg::STAGE_DONE;
            end
            default: begin
              number_stage_next = acp_pkg::STAGE_DONE;
            end
          endcase
        end
      end
    end

    // token ends at a space, or at the end of the frame
    if (number_negative_next) begin
      mclip = (number_magnitude_next > MAG_LIMIT) ? MAG_LIMIT : number_magnitude_next;
      value = -$signed(mclip);
    end else begin
      mclip = (number_magnitude_next > MAG_LIMIT - 1'b1) ? MAG_LIMIT - 1'b1
                                                          : number_magnitude_next;
      value = $signed(mclip);
    end
    if (token_phase_next && !speed_seen && (space_fed || (in_accept && frame_last))) begin
      case (token_letter_next)
        acp_pkg::LETTER_X: x_latched_next = value;
        acp_pkg::LETTER_Y: y_latched_next = value;
        acp_pkg::LETTER_Z: z_latched_next = value;
        acp_pkg::LETTER_S: begin
          speed_seen_next    = 1'b1;
          speed_latched_next = value;
        end
        default: ;
      endcase
      token_phase_next = 1'b0;
    end

    if (out_load) begin
      if (!reset_match_failed_next && (reset_match_pos_next == RESET_LEN)) begin
        kind_next = acp_pkg::KIND_RESET;
      end else if (speed_seen_next) begin
        kind_next  = acp_pkg::KIND_SPEED;
        s_out_next = FB'(speed_latched_next);
      end else begin
        x_out_next = FB'(x_latched_next);
        y_out_next = FB'(y_latched_next);
        z_out_next = FB'(z_latched_next);
      end
      // fresh state for the next frame
      token_phase_next        = 1'b0;
      token_letter_next       = acp_pkg::LETTER_NONE;
      number_stage_next       = acp_pkg::STAGE_BEFORE_SIGN;
      number_negative_next    = 1'b0;
      number_magnitude_next   = '0;
      x_latched_next          = '0;
      y_latched_next          = '0;
      z_latched_next          = '0;
      speed_seen_next         = 1'b0;
      speed_latched_next      = '0;
      reset_match_pos_next    = '0;
      reset_match_failed_next = 1'b0;
      text_ended_next         = 1'b0;
      byte_count_next         = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_phase        <= 1'b0;
      token_letter       <= acp_pkg::LETTER_NONE;
      number_stage       <= acp_pkg::STAGE_BEFORE_SIGN;
      number_negative    <= 1'b0;
      number_magnitude   <= '0;
      x_latched          <= '0;
      y_latched          <= '0;
      z_latched          <= '0;
      speed_seen         <= 1'b0;
      speed_latched      <= '0;
      reset_match_pos    <= '0;
      reset_match_failed <= 1'b0;
      text_ended         <= 1'b0;
      byte_count         <= '0;
    end else begin
      token_phase        <= token_phase_next;
      token_letter       <= token_letter_next;
      number_stage       <= number_stage_next;
      number_negative    <= number_negative_next;
      number_magnitude   <= number_magnitude_next;
      x_latched          <= x_latched_next;
      y_latched          <= y_latched_next;
      z_latched          <= z_latched_next;
      speed_seen         <= speed_seen_next;
      speed_latched      <= speed_latched_next;
      reset_match_pos    <= reset_match_pos_next;
      reset_match_failed <= reset_match_failed_next;
      text_ended         <= text_ended_next;
      byte_count         <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      command_kind <= kind_next;
      target_x     <= x_out_next;
      target_y     <= y_out_next;
      target_z     <= z_out_next;
      speed_value  <= s_out_next;
    end
  end

endmodule

// ===== sim/axis_command_parser_tb.sv =====
`timescale 1ns / 100ps
// axis_command_parser_tb: self-checking bench for the text command decoder
// depends on rtl/acp_pkg.sv and rtl/axis_command_parser.sv

module axis_command_parser_tb;

  localparam logic [31:0] MAG_LIMIT = 32'd1 << (acp_pkg::NUMBER_BITS_DEF - 1);
  localparam logic [8*acp_pkg::RESET_TEXT_LEN-1:0] RESET_WORD = "resetCoord";
  localparam int TOTAL_BYTES    = 750;
  localparam int CALM_FROM      = 620;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  typedef struct {
    acp_pkg::kind_t                         kind;
    logic signed [acp_pkg::FIELD_BITS-1:0]  x;
    logic signed [acp_pkg::FIELD_BITS-1:0]  y;
    logic signed [acp_pkg::FIELD_BITS-1:0]  z;
    logic signed [acp_pkg::FIELD_BITS-1:0]  speed;
  } cmd_t;

  typedef struct {
    string head;
    bit    nul;
    string tail;
    bit    typed;
    cmd_t  want;
  } frame_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [7:0] rx_byte;
  logic frame_last;
  logic out_valid;
  logic out_stall;
  logic [1:0] command_kind;
  logic signed [acp_pkg::FIELD_BITS-1:0] target_x;
  logic signed [acp_pkg::FIELD_BITS-1:0] target_y;
  logic signed [acp_pkg::FIELD_BITS-1:0] target_z;
  logic signed [acp_pkg::FIELD_BITS-1:0] speed_value;

  axis_command_parser DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .frame_last   (frame_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .command_kind (command_kind),
    .target_x     (target_x),
    .target_y     (target_y),
    .target_z     (target_z),
    .speed_value  (speed_value)
  );

  cmd_t        pending_cmds[$];
  frame_row_t  directed_frames[$];
  logic [7:0]  frame_bytes[$];
  bit          failed = 1'b0;
  bit          bursts_on = 1'b0;
  int          bytes_sent = 0;
  int          stuck_cycles = 0;

  // parser state mirrored from the block
  logic                                   in_token;
  acp_pkg::letter_t                       tok_letter;
  acp_pkg::stage_t                        num_stage;
  logic                                   num_neg;
  logic [31:0]                            num_mag;
  logic signed [acp_pkg::FIELD_BITS-1:0]  lat_x, lat_y, lat_z, lat_speed;
  logic                                   speed_hit;
  int                                     match_pos;
  logic                                   match_broken;
  logic                                   text_done;
  int                                     text_bytes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] reset_byte(input int pos);
    return RESET_WORD[8*(acp_pkg::RESET_TEXT_LEN-1-pos) +: 8];
  endfunction

  function automatic void clear_parser();
    in_token     = 1'b0;
    tok_letter   = acp_pkg::LETTER_NONE;
    num_stage    = acp_pkg::STAGE_BEFORE_SIGN;
    num_neg      = 1'b0;
    num_mag      = '0;
    lat_x        = '0;
    lat_y        = '0;
    lat_z        = '0;
    speed_hit    = 1'b0;
    lat_speed    = '0;
    match_pos    = 0;
    match_broken = 1'b0;
    text_done    = 1'b0;
    text_bytes   = 0;
  endfunction

  // clamp the accumulated magnitude to the signed number range
  function automatic logic signed [acp_pkg::FIELD_BITS-1:0] number_result();
    logic [31:0] m;
    m = num_mag;
    if (num_neg) begin
      if (m > MAG_LIMIT) m = MAG_LIMIT;
      m = -m;
    end else if (m > MAG_LIMIT - 1) begin
      m = MAG_LIMIT - 1;
    end
    return m[acp_pkg::FIELD_BITS-1:0];
  endfunction

  function automatic void close_token();
    logic signed [acp_pkg::FIELD_BITS-1:0] v;
    if (!in_token) return;
    v = number_result();
    case (tok_letter)
      acp_pkg::LETTER_X: lat_x = v;
      acp_pkg::LETTER_Y: lat_y = v;
      acp_pkg::LETTER_Z: lat_z = v;
      acp_pkg::LETTER_S: begin
        speed_hit = 1'b1;
        lat_speed = v;
      end
      default: ;
    endcase
    in_token = 1'b0;
  endfunction

  function automatic void add_digit(input logic [7:0] b);
    num_stage = acp_pkg::STAGE_DIGITS;
    num_mag = num_mag * 10 + (b - acp_pkg::CH_ZERO);
    if (num_mag > MAG_LIMIT) num_mag = MAG_LIMIT;
  endfunction

  function automatic void feed_number(input logic [7:0] b);
    logic digit;
    digit = (b >= acp_pkg::CH_ZERO) && (b <= acp_pkg::CH_NINE);
    if (num_stage == acp_pkg::STAGE_BEFORE_SIGN) begin
      if (b >= acp_pkg::CH_TAB && b <= acp_pkg::CH_CR) return;
      if (b == acp_pkg::CH_PLUS) begin
        num_stage = acp_pkg::STAGE_AFTER_SIGN;
      end else if (b == acp_pkg::CH_MINUS) begin
        num_neg = 1'b1;
        num_stage = acp_pkg::STAGE_AFTER_SIGN;
      end else if (digit) begin
        add_digit(b);
      end else begin
        num_stage = acp_pkg::STAGE_DONE;
      end
    end else if (num_stage == acp_pkg::STAGE_AFTER_SIGN ||
                 num_stage == acp_pkg::STAGE_DIGITS) begin
      if (digit) add_digit(b);
      else num_stage = acp_pkg::STAGE_DONE;
    end
  endfunction

  function automatic void feed_char(input logic [7:0] b);
    if (!match_broken && match_pos < acp_pkg::RESET_TEXT_LEN && b == reset_byte(match_pos))
      match_pos++;
    else
      match_broken = 1'b1;
    if (speed_hit) return;
    if (b == acp_pkg::CH_SPACE) begin
      close_token();
    end else if (!in_token) begin
      in_token = 1'b1;
      case (b)
        acp_pkg::CH_X: tok_letter = acp_pkg::LETTER_X;
        acp_pkg::CH_Y: tok_letter = acp_pkg::LETTER_Y;
        acp_pkg::CH_Z: tok_letter = acp_pkg::LETTER_Z;
        acp_pkg::CH_S: tok_letter = acp_pkg::LETTER_S;
        default:       tok_letter = acp_pkg::LETTER_OTHER;
      endcase
      num_stage = acp_pkg::STAGE_BEFORE_SIGN;
      num_neg = 1'b0;
      num_mag = '0;
    end else begin
      feed_number(b);
    end
  endfunction

  // steps the parser by one byte; returns 1 with the command at frame end
  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    output cmd_t cmd);
    cmd.kind = acp_pkg::KIND_MOVE;
    cmd.x = '0;
    cmd.y = '0;
    cmd.z = '0;
    cmd.speed = '0;
    if (!text_done && text_bytes < acp_pkg::MESSAGE_BYTES_DEF) begin
      text_bytes++;
      if (b == acp_pkg::CH_NUL) text_done = 1'b1;
      else feed_char(b);
    end
    if (!last) return 1'b0;
    if (!speed_hit) close_token();
    if (!match_broken && match_pos == acp_pkg::RESET_TEXT_LEN) begin
      cmd.kind = acp_pkg::KIND_RESET;
    end else if (speed_hit) begin
      cmd.kind = acp_pkg::KIND_SPEED;
      cmd.speed = lat_speed;
    end else begin
      cmd.x = lat_x;
      cmd.y = lat_y;
      cmd.z = lat_z;
    end
    clear_parser();
    return 1'b1;
  endfunction

  task automatic add_row(input string head, input bit nul, input string tail,
                         input bit typed, input acp_pkg::kind_t kind,
                         input int x, input int y, input int z, input int s);
    frame_row_t row;
    row.head = head;
    row.nul = nul;
    row.tail = tail;
    row.typed = typed;
    row.want.kind = kind;
    row.want.x = acp_pkg::FIELD_BITS'(x);
    row.want.y = acp_pkg::FIELD_BITS'(y);
    row.want.z = acp_pkg::FIELD_BITS'(z);
    row.want.speed = acp_pkg::FIELD_BITS'(s);
    directed_frames.push_back(row);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = (bursts_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    rx_byte    <= b;
    frame_last <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_frame(input bit typed, input cmd_t want);
    cmd_t got;
    bytes_sent += frame_bytes.size();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      if (parse_byte(frame_bytes[i], i == frame_bytes.size() - 1, got))
        pending_cmds.push_back(typed ? want : got);
    end
  endtask

  task automatic random_frame();
    int pick, ntok, ndig, pos;
    logic [7:0] c;
    frame_bytes.delete();
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      for (int i = 0; i < acp_pkg::RESET_TEXT_LEN; i++) frame_bytes.push_back(reset_byte(i));
      if (pick == 1) begin
        pos = $urandom_range(0, acp_pkg::RESET_TEXT_LEN - 1);
        case ($urandom_range(0, 2))
          0:       frame_bytes[pos] = frame_bytes[pos] ^ (8'd1 << $urandom_range(0, 7));
          1:       frame_bytes.delete(pos);
          default: frame_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
      end else if ($urandom_range(0, 1)) begin
        frame_bytes.push_back(acp_pkg::CH_NUL);
        frame_bytes.push_back(acp_pkg::CH_X);
      end
    end else if (pick == 2) begin
      // raw noise, any byte value
      ntok = $urandom_range(1, 24);
      repeat (ntok) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      ntok = $urandom_range(0, 3);
      for (int t = 0; t < ntok; t++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: c = acp_pkg::CH_X;
          3, 4:    c = acp_pkg::CH_Y;
          5, 6:    c = acp_pkg::CH_Z;
          7:       c = acp_pkg::CH_S;
          default: begin
            c = 8'($urandom_range(1, 255));
            if (c == acp_pkg::CH_SPACE) c = acp_pkg::CH_PLUS;
          end
        endcase
        frame_bytes.push_back(c);
        if ($urandom_range(0, 11) == 0)
          frame_bytes.push_back(8'($urandom_range(acp_pkg::CH_TAB, acp_pkg::CH_CR)));
        case ($urandom_range(0, 3))
          1:       frame_bytes.push_back(acp_pkg::CH_PLUS);
          2:       frame_bytes.push_back(acp_pkg::CH_MINUS);
          default: ;
        endcase
        pick = $urandom_range(0, 15);
        ndig = (pick == 0) ? 0 : (pick < 12) ? $urandom_range(1, 5) : $urandom_range(7, 10);
        repeat (ndig) frame_bytes.push_back(8'(acp_pkg::CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 9) == 0) frame_bytes.push_back(8'($urandom_range(33, 126)));
        if (t < ntok - 1 || $urandom_range(0, 7) == 0) begin
          frame_bytes.push_back(acp_pkg::CH_SPACE);
          if ($urandom_range(0, 5) == 0) frame_bytes.push_back(acp_pkg::CH_SPACE);
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        frame_bytes.push_back(acp_pkg::CH_NUL);
        repeat ($urandom_range(0, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    if (frame_bytes.size() == 0) frame_bytes.push_back(acp_pkg::CH_SPACE);
  endtask

  initial begin : out_stall_gen
    int hold;
    out_stall = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
        if (bursts_on && $urandom_range(0, 7) == 0) hold = $urandom_range(1, 19);
      end
    end
  end

  always @(posedge clk) begin : check_results
    cmd_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        $error("unexpected result beat: command_kind %0d", command_kind);
        failed = 1'b1;
      end else begin
        w = pending_cmds.pop_front();
        if (command_kind !== w.kind) begin
          $error("command_kind: expected %0d, got %0d", w.kind, command_kind);
          failed = 1'b1;
        end
        if (target_x !== w.x) begin
          $error("target_x: expected %0d, got %0d", w.x, target_x);
          failed = 1'b1;
        end
        if (target_y !== w.y) begin
          $error("target_y: expected %0d, got %0d", w.y, target_y);
          failed = 1'b1;
        end
        if (target_z !== w.z) begin
          $error("target_z: expected %0d, got %0d", w.z, target_z);
          failed = 1'b1;
        end
        if (speed_value !== w.speed) begin
          $error("speed_value: expected %0d, got %0d", w.speed, speed_value);
          failed = 1'b1;
        end
      end
    end
  end

  // ends the run when no beat moves on either side for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    cmd_t none;
    rst        = 1'b1;
    in_valid   = 1'b0;
    rx_byte    = 8'h00;
    frame_last = 1'b0;
    clear_parser();
    none.kind = acp_pkg::KIND_MOVE;
    none.x = '0;
    none.y = '0;
    none.z = '0;
    none.speed = '0;

    add_row("resetCoord", 0, "", 1, acp_pkg::KIND_RESET, 0, 0, 0, 0);
    add_row("", 1, "", 1, acp_pkg::KIND_MOVE, 0, 0, 0, 0);
    add_row("X8388607 Y-8388608", 0, "", 1, acp_pkg::KIND_MOVE, 8388607, -8388608, 0, 0);
    add_row("Z99999999", 0, "", 1, acp_pkg::KIND_MOVE, 0, 0, 8388607, 0);
    add_row("S-99999999 X5", 0, "", 1, acp_pkg::KIND_SPEED, 0, 0, 0, -8388608);
    add_row("resetCoord", 1, "Z5", 1, acp_pkg::KIND_RESET, 0, 0, 0, 0);
    add_row("X+12 Q5 S7 Y3", 0, "", 0, acp_pkg::KIND_MOVE, 0, 0, 0, 0);
    add_row("Y\011\012\013\014\015-42 X", 0, "", 0, acp_pkg::KIND_MOVE, 0, 0, 0, 0);
    add_row("X12a3 Z- S", 0, "", 0, acp_pkg::KIND_MOVE, 0, 0, 0, 0);
    add_row("\3771 x9 Y\2008", 0, "", 0, acp_pkg::KIND_MOVE, 0, 0, 0, 0);
    add_row("X1", 1, "X2", 0, acp_pkg::KIND_MOVE, 0, 0, 0, 0);
    add_row("X1 Y2 Z3 X4 Y5 Z6 X789", 0, "", 0, acp_pkg::KIND_MOVE, 0, 0, 0, 0);
    add_row("resetCoordX", 0, "", 0, acp_pkg::KIND_MOVE, 0, 0, 0, 0);
    add_row("  X-0 Y+ Z+-3", 0, "", 0, acp_pkg::KIND_MOVE, 0, 0, 0, 0);

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_frames[r]) begin
      bursts_on = ($urandom_range(0, 3) != 0);
      frame_bytes.delete();
      for (int i = 0; i < directed_frames[r].head.len(); i++)
        frame_bytes.push_back(directed_frames[r].head[i]);
      if (directed_frames[r].nul) frame_bytes.push_back(acp_pkg::CH_NUL);
      for (int i = 0; i < directed_frames[r].tail.len(); i++)
        frame_bytes.push_back(directed_frames[r].tail[i]);
      send_frame(directed_frames[r].typed, directed_frames[r].want);
    end

    while (bytes_sent < TOTAL_BYTES) begin
      // the last stretch runs with both sides at full rate
      bursts_on = (bytes_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
      random_frame();
      send_frame(1'b0, none);
    end
    bursts_on = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && pending_cmds.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== axis_command_parser.f =====
rtl/acp_pkg.sv
rtl/axis_command_parser.sv
sim/axis_command_parser_tb.sv
